### rtl/slowpwm_pkg.sv
// ----------------------------------------------------------------------------
// slowpwm_pkg: shared types and constants for the slow PWM generator
// Field widths, command and register codes, reset values, FSM state types.
// ----------------------------------------------------------------------------
package slowpwm_pkg;

	localparam int TIME_BITS = 24;
	localparam int DUTY_BITS = 16;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_RESOLUTION = 2'd0;
	localparam logic [1:0] REG_PERIOD     = 2'd1;
	localparam logic [1:0] REG_BUSY_MIN   = 2'd2;
	localparam logic [1:0] REG_BUSY_MAX   = 2'd3;

	// register reset values, truncated to the configured widths at the top level
	localparam int RST_RESOLUTION = 100;
	localparam int RST_PERIOD_MS  = 1000;
	localparam int RST_BUSY_MIN   = 0;
	localparam int RST_BUSY_MAX   = 1000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_CMP,
		ST_FIN
	} pwm_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

endpackage

### rtl/slowpwm_muldiv.sv
// ----------------------------------------------------------------------------
// slowpwm_muldiv: bit-serial floor(mcand * mplier / divisor)
// Shift-add multiply, one multiplier bit a cycle, then restoring division,
// one quotient bit a cycle. Requires mplier <= divisor, so that the quotient
// fits in TIME_BITS and the top DUTY_BITS of the product stay below divisor.
// ----------------------------------------------------------------------------
module slowpwm_muldiv #(
	parameter int TIME_BITS = slowpwm_pkg::TIME_BITS,
	parameter int DUTY_BITS = slowpwm_pkg::DUTY_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_BITS-1:0] mcand,
	input  logic [DUTY_BITS-1:0] mplier,
	input  logic [DUTY_BITS-1:0] divisor,
	output logic                 done,
	output logic [TIME_BITS-1:0] quot
);

	localparam int CNT_MAX = (TIME_BITS > DUTY_BITS) ? TIME_BITS : DUTY_BITS;
	localparam int CW      = $clog2(CNT_MAX);
	localparam int PW      = TIME_BITS + DUTY_BITS;

	slowpwm_pkg::md_state_t state_q;
	logic [CW-1:0]        cnt_q;
	logic [TIME_BITS-1:0] mcand_q;
	logic [DUTY_BITS-1:0] div_q;
	logic [TIME_BITS-1:0] hi_q;
	logic [DUTY_BITS-1:0] lo_q;
	logic [DUTY_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0] qsh_q;
	logic                 done_q;

	logic [TIME_BITS:0]   sum;
	logic [PW-1:0]        prod_n;
	logic [DUTY_BITS:0]   rem_sh;
	logic                 ge;
	logic [DUTY_BITS:0]   rem_sub;

	always_comb begin
		sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
		prod_n  = {sum, lo_q[DUTY_BITS-1:1]};
		rem_sh  = {rem_q, qsh_q[TIME_BITS-1]};
		ge      = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slowpwm_pkg::MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				slowpwm_pkg::MD_IDLE: begin
					if (start) begin
						state_q <= slowpwm_pkg::MD_MUL;
						cnt_q   <= CW'(DUTY_BITS - 1);
					end
				end
				slowpwm_pkg::MD_MUL: begin
					if (cnt_q == '0) begin
						state_q <= slowpwm_pkg::MD_DIV;
						cnt_q   <= CW'(TIME_BITS - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				slowpwm_pkg::MD_DIV: begin
					if (cnt_q == '0) begin
						state_q <= slowpwm_pkg::MD_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= slowpwm_pkg::MD_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			slowpwm_pkg::MD_IDLE: begin
				if (start) begin
					mcand_q <= mcand;
					div_q   <= divisor;
					hi_q    <= '0;
					lo_q    <= mplier;
				end
			end
			slowpwm_pkg::MD_MUL: begin
				hi_q <= prod_n[PW-1:DUTY_BITS];
				lo_q <= prod_n[DUTY_BITS-1:0];
				if (cnt_q == '0) begin
					// top part of the product is already below the divisor
					rem_q <= prod_n[PW-1:TIME_BITS];
					qsh_q <= prod_n[TIME_BITS-1:0];
				end
			end
			slowpwm_pkg::MD_DIV: begin
				rem_q <= ge ? rem_sub[DUTY_BITS-1:0] : rem_sh[DUTY_BITS-1:0];
				qsh_q <= {qsh_q[TIME_BITS-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = qsh_q;

endmodule

### rtl/slow_pwm_generator.sv
// ----------------------------------------------------------------------------
// slow_pwm_generator: software-style PWM with minimum and maximum busy time
//
//   channel  dir  transfer carries
//   s_*      in   one command: tick, start or stop, with a duty request
//   m_*      out  one result per command: pin level, pin written, idle clipped
//   cfg_*    in   register write: resolution, period, busy min, busy max
//
// A command that leaves the duty unchanged goes from idle straight to the
// finish state; one that changes it passes through calc, held there by the
// bit-serial muldiv unit, then cmp. One command is in work at a time; a
// finished result sits in the output register while the next command enters.
// If that register is still full when a result is ready, the block holds.
// Reset restores register defaults and the idle phase; no clearing pass.
// ----------------------------------------------------------------------------
module slow_pwm_generator #(
	parameter int TIME_BITS = slowpwm_pkg::TIME_BITS,
	parameter int DUTY_BITS = slowpwm_pkg::DUTY_BITS
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                               s_tvalid,
	output logic                               s_tready,
	// duty_request
	input  logic [((DUTY_BITS+7)/8)*8-1:0]     s_tdata,
	// cmd
	input  logic [1:0]                         s_tuser,

	output logic                               m_tvalid,
	input  logic                               m_tready,
	// pin_level, pin_written, delay_clipped, zero fill
	output logic [7:0]                         m_tdata,

	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [((TIME_BITS > DUTY_BITS) ? TIME_BITS : DUTY_BITS)-1:0] cfg_data
);

	localparam logic [DUTY_BITS-1:0] RST_RES  = DUTY_BITS'(slowpwm_pkg::RST_RESOLUTION);
	localparam logic [TIME_BITS-1:0] RST_PER  = TIME_BITS'(slowpwm_pkg::RST_PERIOD_MS);
	localparam logic [TIME_BITS-1:0] RST_MIN  = TIME_BITS'(slowpwm_pkg::RST_BUSY_MIN);
	localparam logic [TIME_BITS-1:0] RST_MAX  = TIME_BITS'(slowpwm_pkg::RST_BUSY_MAX);
	localparam logic [TIME_BITS-1:0] RST_IDLE = (RST_MIN > RST_PER) ? '0 : RST_PER - RST_MIN;

	// configuration registers
	logic [DUTY_BITS-1:0] res_q;
	logic [TIME_BITS-1:0] period_q;
	logic [TIME_BITS-1:0] min_q;
	logic [TIME_BITS-1:0] max_q;

	// PWM state
	slowpwm_pkg::pwm_state_t state_q, state_d;
	logic [1:0]           cmd_q;
	logic [DUTY_BITS-1:0] duty_q;
	logic [TIME_BITS-1:0] busy_q;
	logic [TIME_BITS-1:0] idle_q;
	logic [TIME_BITS-1:0] wait_q;
	logic                 phase_q;
	logic                 level_q;
	logic                 clip_q;
	logic                 span_ok_q;

	// output register
	logic                 m_valid_q;
	logic                 out_level_q;
	logic                 out_written_q;
	logic                 out_clip_q;

	logic                 accept;
	logic                 recompute;
	logic [DUTY_BITS-1:0] new_duty;
	logic                 span_ok;
	logic [TIME_BITS-1:0] mcand;
	logic                 md_start;
	logic                 md_done;
	logic [TIME_BITS-1:0] md_quot;
	logic                 out_free;
	logic                 fin_fire;

	logic [TIME_BITS-1:0] wait_n;
	logic                 phase_n;
	logic                 level_n;
	logic                 written_n;

	logic [DUTY_BITS-1:0] req;
	logic [1:0]           cmd;

	assign req    = s_tdata[DUTY_BITS-1:0];
	assign cmd    = s_tuser;
	assign accept = s_tvalid && s_tready;

	// duty take-up decision for the incoming command
	always_comb begin
		recompute = 1'b0;
		new_duty  = '0;
		unique case (cmd)
			slowpwm_pkg::CMD_TICK: begin
				recompute = req != duty_q;
				new_duty  = (req > res_q) ? res_q : req;
			end
			slowpwm_pkg::CMD_START: begin
				recompute = duty_q != '0;
			end
			default: ;
		endcase
		span_ok = (max_q > min_q) && (res_q != '0);
		mcand   = span_ok ? (max_q - min_q) : '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			slowpwm_pkg::ST_IDLE: begin
				if (accept)
					state_d = recompute ? slowpwm_pkg::ST_CALC : slowpwm_pkg::ST_FIN;
			end
			slowpwm_pkg::ST_CALC: begin
				if (md_done)
					state_d = slowpwm_pkg::ST_CMP;
			end
			slowpwm_pkg::ST_CMP: state_d = slowpwm_pkg::ST_FIN;
			slowpwm_pkg::ST_FIN: begin
				if (out_free)
					state_d = slowpwm_pkg::ST_IDLE;
			end
			default: state_d = slowpwm_pkg::ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		out_free = !m_valid_q || m_tready;
		s_tready = state_q == slowpwm_pkg::ST_IDLE;
		md_start = accept && recompute;
		fin_fire = (state_q == slowpwm_pkg::ST_FIN) && out_free;
	end

	// command effect on countdown, phase and pin
	always_comb begin
		wait_n    = wait_q;
		phase_n   = phase_q;
		level_n   = level_q;
		written_n = 1'b0;
		unique case (cmd_q)
			slowpwm_pkg::CMD_TICK: begin
				if (wait_q == '0) begin
					if (!phase_q) begin
						wait_n  = busy_q;
						phase_n = 1'b1;
						if (busy_q != '0) begin
							level_n   = 1'b1;
							written_n = 1'b1;
						end
					end else begin
						wait_n  = idle_q;
						phase_n = 1'b0;
						if (idle_q != '0) begin
							level_n   = 1'b0;
							written_n = 1'b1;
						end
					end
				end else begin
					wait_n = wait_q - 1'b1;
				end
			end
			slowpwm_pkg::CMD_START: begin
				wait_n  = '0;
				phase_n = 1'b0;
			end
			slowpwm_pkg::CMD_STOP: begin
				level_n   = 1'b0;
				written_n = 1'b1;
				phase_n   = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= slowpwm_pkg::ST_IDLE;
			res_q     <= RST_RES;
			period_q  <= RST_PER;
			min_q     <= RST_MIN;
			max_q     <= RST_MAX;
			duty_q    <= '0;
			busy_q    <= RST_MIN;
			idle_q    <= RST_IDLE;
			wait_q    <= '0;
			phase_q   <= 1'b0;
			level_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					slowpwm_pkg::REG_RESOLUTION: res_q    <= cfg_data[DUTY_BITS-1:0];
					slowpwm_pkg::REG_PERIOD:     period_q <= cfg_data[TIME_BITS-1:0];
					slowpwm_pkg::REG_BUSY_MIN:   min_q    <= cfg_data[TIME_BITS-1:0];
					slowpwm_pkg::REG_BUSY_MAX:   max_q    <= cfg_data[TIME_BITS-1:0];
					default: ;
				endcase
			end

			if (md_start)
				duty_q <= new_duty;

			if (state_q == slowpwm_pkg::ST_CALC && md_done)
				busy_q <= (span_ok_q ? md_quot : '0) + min_q;

			if (state_q == slowpwm_pkg::ST_CMP)
				idle_q <= (busy_q > period_q) ? '0 : period_q - busy_q;

			if (fin_fire) begin
				wait_q    <= wait_n;
				phase_q   <= phase_n;
				level_q   <= level_n;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			span_ok_q <= span_ok;
		end
		if (accept)
			clip_q <= 1'b0;
		else if (state_q == slowpwm_pkg::ST_CMP)
			clip_q <= busy_q > period_q;
		if (fin_fire) begin
			out_level_q   <= level_n;
			out_written_q <= written_n;
			out_clip_q    <= clip_q;
		end
	end

	slowpwm_muldiv #(
		.TIME_BITS(TIME_BITS),
		.DUTY_BITS(DUTY_BITS)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.mcand  (mcand),
		.mplier (new_duty),
		.divisor(res_q),
		.done   (md_done),
		.quot   (md_quot)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, out_clip_q, out_written_q, out_level_q};

endmodule

### test/slow_pwm_generator_test.sv
// ----------------------------------------------------------------------------
// slow_pwm_generator_test: self-checking bench for the slow PWM generator
// A directed table covers reset behavior, every command, clamping, the
// inverted busy range, zero resolution and idle-time saturation. It is
// followed by random command streams under several register settings.
// Results are checked against a typed table expectation or a cycle-free
// phase countdown predictor. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module slow_pwm_generator_test;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         RAND_PHASES = 13;
	localparam int         PHASE_ITEMS = 100;

	// one result transfer, bit 0 up: level, written, clipped
	typedef struct packed {
		logic clipped;
		logic written;
		logic level;
	} pin_result_t;

	typedef struct packed {
		logic        is_reg;
		logic [1:0]  code;   // command, or register index
		logic [23:0] value;  // duty request, or register data
		logic        typed;  // use the expectation below instead of the predictor
		pin_result_t want;
	} plan_row_t;

	localparam int PLAN_LEN = 32;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// reg   code                        value        typed  clip/wr/lvl
		'{1'b0, CMD_UNUSED,                 24'h000000, 1'b1, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_STOP,      24'h00FFFF, 1'b1, 3'b010},
		// toggle into busy, zero delay
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h000000, 1'b1, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'd50,     1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_START,     24'h001234, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'd100,    1'b0, 3'b000},
		// above resolution, clamps
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h00FFFF, 1'b0, 3'b000},
		// equal to held duty
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'd100,    1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_STOP,      24'h000000, 1'b1, 3'b010},
		'{1'b0, slowpwm_pkg::CMD_START,     24'h000000, 1'b0, 3'b000},
		// duty already zero
		'{1'b0, slowpwm_pkg::CMD_START,     24'h000000, 1'b0, 3'b000},
		// min above max and period
		'{1'b1, slowpwm_pkg::REG_BUSY_MIN,  24'd2000,   1'b0, 3'b000},
		// no recompute on same duty
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h000000, 1'b0, 3'b000},
		// idle saturates
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'd7,      1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'd7,      1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_RESOLUTION, 24'd0,     1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_BUSY_MIN,  24'd3,      1'b0, 3'b000},
		// zero resolution
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'd9,      1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_STOP,      24'h000000, 1'b1, 3'b010},
		'{1'b1, slowpwm_pkg::REG_RESOLUTION, 24'h00FFFF, 1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_PERIOD,    24'hFFFFFF, 1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_BUSY_MIN,  24'h000000, 1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_BUSY_MAX,  24'hFFFFFF, 1'b0, 3'b000},
		// full span
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h00FFFF, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_START,     24'h000000, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h008000, 1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_PERIOD,    24'h000000, 1'b0, 3'b000},
		'{1'b1, slowpwm_pkg::REG_BUSY_MAX,  24'h000000, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h000001, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h000001, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h00AAAA, 1'b0, 3'b000},
		'{1'b0, slowpwm_pkg::CMD_TICK,      24'h005555, 1'b0, 3'b000}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;  // duty_request
	logic [1:0]  s_tuser   = slowpwm_pkg::CMD_TICK;  // cmd
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;  // pin_level, pin_written, delay_clipped, zero fill
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = slowpwm_pkg::REG_RESOLUTION;
	logic [23:0] cfg_data  = '0;

	// predictor copy of registers and state
	logic [15:0] res_steps;
	logic [23:0] period_ticks, min_ticks, max_ticks;
	logic [15:0] duty_held;
	logic [23:0] busy_ticks, idle_ticks, countdown;
	logic        in_busy, level_now;

	pin_result_t pin_expected [$];
	int          fails     = 0;
	bit          gaps_on   = 1'b1;
	bit          stalls_on = 1'b1;
	int          stall_left = 0;

	slow_pwm_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic delays_update();
		logic [63:0] scaled;
		scaled = '0;
		if (max_ticks > min_ticks && res_steps != 0)
			scaled = (64'(max_ticks - min_ticks) * 64'(duty_held)) / 64'(res_steps);
		busy_ticks = 24'(scaled + 64'(min_ticks));
		if (busy_ticks > period_ticks) begin
			idle_ticks = '0;
			return 1'b1;
		end
		idle_ticks = period_ticks - busy_ticks;
		return 1'b0;
	endfunction

	function automatic logic duty_take(logic [15:0] req);
		if (req == duty_held)
			return 1'b0;
		duty_held = (req > res_steps) ? res_steps : req;
		return delays_update();
	endfunction

	function automatic pin_result_t pwm_step(logic [1:0] cmd, logic [15:0] req);
		pin_result_t r;
		r = '0;
		case (cmd)
			slowpwm_pkg::CMD_TICK: begin
				r.clipped = duty_take(req);
				if (countdown == 0) begin
					if (!in_busy) begin
						countdown = busy_ticks;
						if (busy_ticks != 0) begin
							level_now = 1'b1;
							r.written = 1'b1;
						end
					end else begin
						countdown = idle_ticks;
						if (idle_ticks != 0) begin
							level_now = 1'b0;
							r.written = 1'b1;
						end
					end
					in_busy = !in_busy;
				end else begin
					countdown = countdown - 1'b1;
				end
			end
			slowpwm_pkg::CMD_START: begin
				r.clipped = duty_take('0);
				countdown = '0;
				in_busy   = 1'b0;
			end
			slowpwm_pkg::CMD_STOP: begin
				level_now = 1'b0;
				r.written = 1'b1;
				in_busy   = 1'b0;
			end
			default: ;
		endcase
		r.level = level_now;
		return r;
	endfunction

	function automatic logic [23:0] pick_ticks(int unsigned small_hi);
		case ($urandom_range(0, 9))
			0: return 24'hFFFFFF;
			1: return 24'($urandom);
			2: return '0;
			default: return 24'($urandom_range(0, small_hi));
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input logic [1:0] cmd, input logic [15:0] duty,
			input logic typed, input pin_result_t want);
		pin_result_t predicted;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= duty;
		do @(posedge clk); while (!s_tready);
		predicted = pwm_step(cmd, duty);
		pin_expected.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pin_expected.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(negedge clk);
		case (index)
			slowpwm_pkg::REG_RESOLUTION: res_steps    = value[15:0];
			slowpwm_pkg::REG_PERIOD:     period_ticks = value;
			slowpwm_pkg::REG_BUSY_MIN:   min_ticks    = value;
			slowpwm_pkg::REG_BUSY_MAX:   max_ticks    = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		if (!stalls_on) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pin_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pin_expected.size() == 0) begin
				$error("result transfer with nothing expected: m_tdata %b", m_tdata);
				fails++;
			end else begin
				want = pin_expected.pop_front();
				if (m_tdata[0] !== want.level) begin
					$error("pin_level: expected %0d, got %0d", want.level, m_tdata[0]);
					fails++;
				end
				if (m_tdata[1] !== want.written) begin
					$error("pin_written: expected %0d, got %0d", want.written, m_tdata[1]);
					fails++;
				end
				if (m_tdata[2] !== want.clipped) begin
					$error("delay_clipped: expected %0d, got %0d", want.clipped, m_tdata[2]);
					fails++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("slow_pwm_generator regression: fail");
		$finish;
	end

	initial begin
		logic [1:0]  cmd;
		logic [15:0] duty;
		int unsigned roll;

		res_steps    = 16'(slowpwm_pkg::RST_RESOLUTION);
		period_ticks = 24'(slowpwm_pkg::RST_PERIOD_MS);
		min_ticks    = 24'(slowpwm_pkg::RST_BUSY_MIN);
		max_ticks    = 24'(slowpwm_pkg::RST_BUSY_MAX);
		duty_held    = '0;
		busy_ticks   = min_ticks;
		idle_ticks   = (min_ticks > period_ticks) ? '0 : period_ticks - min_ticks;
		countdown    = '0;
		in_busy      = 1'b0;
		level_now    = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].is_reg) begin
				wait_drained();
				write_reg(PLAN[i].code, PLAN[i].value);
			end else begin
				send_item(PLAN[i].code, PLAN[i].value[15:0], PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			// the closing phases run at full rate on both sides
			gaps_on   = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
			stalls_on = (ph < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 7))
				0: write_reg(slowpwm_pkg::REG_RESOLUTION, 24'd1);
				1: write_reg(slowpwm_pkg::REG_RESOLUTION, 24'h00FFFF);
				2: write_reg(slowpwm_pkg::REG_RESOLUTION,
					24'($urandom_range(1, 16'hFFFF)));
				default: write_reg(slowpwm_pkg::REG_RESOLUTION,
					24'($urandom_range(1, 12)));
			endcase
			write_reg(slowpwm_pkg::REG_PERIOD, pick_ticks(24));
			write_reg(slowpwm_pkg::REG_BUSY_MIN, pick_ticks(16));
			write_reg(slowpwm_pkg::REG_BUSY_MAX, pick_ticks(30));

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				cmd = (roll < 80) ? slowpwm_pkg::CMD_TICK :
					(roll < 88) ? slowpwm_pkg::CMD_START :
					(roll < 96) ? slowpwm_pkg::CMD_STOP : CMD_UNUSED;
				case ($urandom_range(0, 9))
					0: duty = duty_held;
					1: duty = 16'($urandom);
					2: duty = res_steps + 16'($urandom_range(0, 3));
					default: duty = 16'($urandom_range(0, res_steps));
				endcase
				send_item(cmd, duty, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (60) @(negedge clk);
		if (fails == 0 && pin_expected.size() == 0)
			$display("slow_pwm_generator regression: pass");
		else
			$display("slow_pwm_generator regression: fail");
		$finish;
	end

endmodule

### files.f
rtl/slowpwm_pkg.sv
rtl/slowpwm_muldiv.sv
rtl/slow_pwm_generator.sv
test/slow_pwm_generator_test.sv
